// ===== design/erd_pkg.sv =====
package erd_pkg;

    localparam int FRAC_BITS_DEF     = 16;
    localparam int CORDIC_STAGES_DEF = 18;

    localparam int WQ        = 30;
    localparam int TABLE_LEN = 28;
    localparam int XW        = 34;

    localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
    localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
    localparam logic signed [XW-1:0] INV_GAIN_Q30 = XW'(36'sh026DD3B6A);
    localparam logic signed [23:0] COEF_Q16    = 24'sd2463238;

    localparam logic [31:0] ATAN_Q30 [TABLE_LEN] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
        32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
        32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
        32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
        32'h0000001F, 32'h0000000F, 32'h00000007
    };

    // angle word wide enough for any field pattern and for pi
    function automatic int angle_width(input int frac);
        return (WQ - frac + 20 > 36) ? WQ - frac + 20 : 36;
    endfunction

endpackage

// ===== design/erd_cordic.sv =====
module erd_cordic #(
    parameter int AW            = 36,
    parameter int CORDIC_STAGES = erd_pkg::CORDIC_STAGES_DEF
) (
    input  logic                          aclk,
    input  logic                          en,
    input  logic signed [AW-1:0]          angle,
    output logic signed [erd_pkg::XW-1:0] sin_out,
    output logic signed [erd_pkg::XW-1:0] cos_out
);

    localparam int XW = erd_pkg::XW;

    logic signed [AW-1:0] pre_a_reg;
    logic                 pre_neg_reg;
    logic signed [AW-1:0] a_reg   [CORDIC_STAGES];
    logic signed [XW-1:0] x_reg   [CORDIC_STAGES];
    logic signed [XW-1:0] y_reg   [CORDIC_STAGES];
    logic                 neg_reg [CORDIC_STAGES];
    logic signed [XW-1:0] sin_reg;
    logic signed [XW-1:0] cos_reg;

    // fold into +-pi/2
    always_ff @(posedge aclk) begin
        if (en) begin
            if (angle > AW'(erd_pkg::HALF_PI_Q30)) begin
                pre_a_reg   <= angle - AW'(erd_pkg::PI_Q30);
                pre_neg_reg <= 1'b1;
            end else if (angle < -AW'(erd_pkg::HALF_PI_Q30)) begin
                pre_a_reg   <= angle + AW'(erd_pkg::PI_Q30);
                pre_neg_reg <= 1'b1;
            end else begin
                pre_a_reg   <= angle;
                pre_neg_reg <= 1'b0;
            end
        end
    end

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_iter
        logic signed [AW-1:0] a_in;
        logic signed [XW-1:0] x_in;
        logic signed [XW-1:0] y_in;
        logic                 neg_in;
        logic signed [AW-1:0] step;

        if (i == 0) begin : g_first
            assign a_in   = pre_a_reg;
            assign x_in   = erd_pkg::INV_GAIN_Q30;
            assign y_in   = '0;
            assign neg_in = pre_neg_reg;
        end else begin : g_next
            assign a_in   = a_reg[i-1];
            assign x_in   = x_reg[i-1];
            assign y_in   = y_reg[i-1];
            assign neg_in = neg_reg[i-1];
        end

        assign step = AW'({1'b0, erd_pkg::ATAN_Q30[i]});

        always_ff @(posedge aclk) begin
            if (en) begin
                if (a_in >= 0) begin
                    x_reg[i] <= x_in - (y_in >>> i);
                    y_reg[i] <= y_in + (x_in >>> i);
                    a_reg[i] <= a_in - step;
                end else begin
                    x_reg[i] <= x_in + (y_in >>> i);
                    y_reg[i] <= y_in - (x_in >>> i);
                    a_reg[i] <= a_in + step;
                end
                neg_reg[i] <= neg_in;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sin_reg <= neg_reg[CORDIC_STAGES-1] ? -y_reg[CORDIC_STAGES-1]
                                                 : y_reg[CORDIC_STAGES-1];
            cos_reg <= neg_reg[CORDIC_STAGES-1] ? -x_reg[CORDIC_STAGES-1]
                                                 : x_reg[CORDIC_STAGES-1];
        end
    end

    assign sin_out = sin_reg;
    assign cos_out = cos_reg;

endmodule

// ===== design/erd_product.sv =====
module erd_product #(
    parameter int FRAC_BITS = erd_pkg::FRAC_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          en,
    input  logic signed [erd_pkg::XW-1:0] sin_lat,
    input  logic signed [erd_pkg::XW-1:0] cos_lat,
    input  logic signed [erd_pkg::XW-1:0] sin_dec,
    input  logic signed [erd_pkg::XW-1:0] cos_dec,
    input  logic signed [erd_pkg::XW-1:0] sin_ws,
    input  logic [17:0]                   sunset_angle,
    input  logic [16:0]                   distance_factor,
    input  logic                          data_ok,
    output logic [23:0]                   radiation,
    output logic                          status
);

    localparam int XW  = erd_pkg::XW;
    localparam int WQ  = erd_pkg::WQ;
    localparam int PW  = 2 * XW;
    localparam int AW  = (52 - FRAC_BITS > 34) ? 52 - FRAC_BITS : 34;
    localparam int MW  = AW + 24;
    localparam int TW  = AW + 8;
    localparam int TFW = TW - (WQ - FRAC_BITS);
    localparam int RW  = TFW + 19;
    localparam logic signed [RW-1:0] LIM  = RW'(64) <<< FRAC_BITS;
    localparam logic signed [RW-1:0] HALF = RW'(1) <<< (FRAC_BITS - 1);

    logic signed [PW-1:0] pss_full, pcc_full;
    logic signed [XW-1:0] pss_reg, pcc_reg, sw1_reg;
    logic [17:0]          sa1_reg;
    logic [16:0]          dr1_reg, dr2_reg, dr3_reg;
    logic                 ok1_reg, ok2_reg, ok3_reg, ok4_reg;

    logic signed [XW+18:0] ta_full;
    logic signed [PW-1:0]  tb_full;
    logic signed [AW-1:0]  ta_reg, tb_reg;

    logic signed [MW-1:0]  sum_scaled;
    logic signed [TW-1:0]  t_reg;

    logic signed [TFW-1:0] tf;
    logic signed [RW-1:0]  r_full;
    logic signed [RW-1:0]  r_reg;

    logic [23:0]           rad_reg;
    logic                  sts_reg;

    assign pss_full = PW'(sin_lat) * PW'(sin_dec);
    assign pcc_full = PW'(cos_lat) * PW'(cos_dec);

    always_ff @(posedge aclk) begin
        if (en) begin
            pss_reg <= XW'(pss_full >>> WQ);
            pcc_reg <= XW'(pcc_full >>> WQ);
            sw1_reg <= sin_ws;
            sa1_reg <= sunset_angle;
            dr1_reg <= distance_factor;
            ok1_reg <= data_ok;
        end
    end

    // ws * sin*sin with ws taken straight from the field
    assign ta_full = (XW+19)'($signed({1'b0, sa1_reg})) * (XW+19)'(pss_reg);
    assign tb_full = PW'(sw1_reg) * PW'(pcc_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            ta_reg  <= AW'(ta_full >>> FRAC_BITS);
            tb_reg  <= AW'(tb_full >>> WQ);
            dr2_reg <= dr1_reg;
            ok2_reg <= ok1_reg;
        end
    end

    assign sum_scaled = (MW'(ta_reg) + MW'(tb_reg)) * MW'(erd_pkg::COEF_Q16);

    always_ff @(posedge aclk) begin
        if (en) begin
            t_reg   <= TW'(sum_scaled >>> 16);
            dr3_reg <= dr2_reg;
            ok3_reg <= ok2_reg;
        end
    end

    assign tf     = TFW'(t_reg >>> (WQ - FRAC_BITS));
    assign r_full = RW'(tf) * RW'($signed({1'b0, dr3_reg})) + HALF;

    always_ff @(posedge aclk) begin
        if (en) begin
            r_reg   <= r_full >>> FRAC_BITS;
            ok4_reg <= ok3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            priority if (!ok4_reg) begin
                rad_reg <= '0;
            end else if (r_reg > LIM) begin
                rad_reg <= LIM[23:0];
            end else if (r_reg < -LIM) begin
                rad_reg <= 24'(-LIM);
            end else begin
                rad_reg <= r_reg[23:0];
            end
            sts_reg <= !ok4_reg;
        end
    end

    assign radiation = rad_reg;
    assign status    = sts_reg;

endmodule

// ===== design/extraterrestrial_radiation_daily.sv =====
// channel  role    tdata (low bit up)                                       tuser
// s_       input   latitude 18, declination 18, sunset_angle 18,            inputs_valid
//                  distance_factor 17, pad 1
// m_       result  radiation 24                                             status
//
// one item per cycle while the pipeline is not stalled; cordic lanes then multiply chain
// aresetn clears the valid bits only; data registers carry no reset
// the whole pipeline advances when the result register is empty or taken
// a stall holds every stage in place
module extraterrestrial_radiation_daily #(
    parameter int FRAC_BITS     = erd_pkg::FRAC_BITS_DEF,
    parameter int CORDIC_STAGES = erd_pkg::CORDIC_STAGES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // latitude, declination, sunset_angle, distance_factor
    input  logic        s_tuser,   // inputs_valid
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // radiation
    output logic        m_tuser    // status
);

    localparam int XW  = erd_pkg::XW;
    localparam int AW  = erd_pkg::angle_width(FRAC_BITS);
    localparam int SH  = erd_pkg::WQ - FRAC_BITS;
    localparam int LC  = CORDIC_STAGES + 2;
    localparam int LAT = LC + 5;

    logic                 en;
    logic [LAT-1:0]       vld_reg;
    logic signed [AW-1:0] lat_q, dec_q, ws_q;
    logic signed [XW-1:0] sl, cl, sd, cd, sw, cw;
    logic [17:0]          sa_reg [LC];
    logic [16:0]          dr_reg [LC];
    logic                 ok_reg [LC];
    logic [23:0]          rad;
    logic                 sts;

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    assign lat_q = $signed({{(AW-18){s_tdata[17]}}, s_tdata[17:0]}) <<< SH;
    assign dec_q = $signed({{(AW-18){s_tdata[35]}}, s_tdata[35:18]}) <<< SH;
    assign ws_q  = $signed({{(AW-18){1'b0}}, s_tdata[53:36]}) <<< SH;

    erd_cordic #(.AW(AW), .CORDIC_STAGES(CORDIC_STAGES)) u_lat (
        .aclk(aclk), .en(en), .angle(lat_q), .sin_out(sl), .cos_out(cl)
    );
    erd_cordic #(.AW(AW), .CORDIC_STAGES(CORDIC_STAGES)) u_dec (
        .aclk(aclk), .en(en), .angle(dec_q), .sin_out(sd), .cos_out(cd)
    );
    erd_cordic #(.AW(AW), .CORDIC_STAGES(CORDIC_STAGES)) u_ws (
        .aclk(aclk), .en(en), .angle(ws_q), .sin_out(sw), .cos_out(cw)
    );

    // side data alongside the cordic lanes
    always_ff @(posedge aclk) begin
        if (en) begin
            sa_reg[0] <= s_tdata[53:36];
            dr_reg[0] <= s_tdata[70:54];
            ok_reg[0] <= s_tuser;
            for (int i = 1; i < LC; i++) begin
                sa_reg[i] <= sa_reg[i-1];
                dr_reg[i] <= dr_reg[i-1];
                ok_reg[i] <= ok_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
        end
    end

    erd_product #(.FRAC_BITS(FRAC_BITS)) u_prod (
        .aclk(aclk),
        .en(en),
        .sin_lat(sl),
        .cos_lat(cl),
        .sin_dec(sd),
        .cos_dec(cd),
        .sin_ws(cw[XW-1] ? sw : sw),
        .sunset_angle(sa_reg[LC-1]),
        .distance_factor(dr_reg[LC-1]),
        .data_ok(ok_reg[LC-1]),
        .radiation(rad),
        .status(sts)
    );

    assign m_tvalid = vld_reg[LAT-1];
    assign m_tdata  = rad;
    assign m_tuser  = sts;

endmodule

// ===== design/erd_checker.sv =====
module erd_checker #(
    parameter int FRAC_BITS = erd_pkg::FRAC_BITS_DEF
) (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tuser
);

    localparam logic signed [31:0] LIM = 32'(64) <<< FRAC_BITS;

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_ready_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tready || !m_tvalid) |-> s_tready)
        else $error("input stalled with free output");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled item changed");

    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("invalid item carries data");

    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (32'($signed(m_tdata)) <= LIM && 32'($signed(m_tdata)) >= -LIM))
        else $error("radiation beyond limit");

endmodule

bind extraterrestrial_radiation_daily erd_checker #(.FRAC_BITS(FRAC_BITS)) u_erd_checker (
    .aclk(aclk),
    .aresetn(aresetn),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser)
);
